>>> design/ptpd_pkg.sv
package ptpd_pkg;

    localparam logic [7:0] HDR_PAD  = 8'h00;
    localparam logic [7:0] HDR_END  = 8'h01;
    localparam logic [7:0] HDR_TIME = 8'b0111_0001;

    localparam logic [4:0] HDR_ADDR_PFX    = 5'b10110;
    localparam logic [4:0] HDR_COUNTER_PFX = 5'b10011;
    localparam logic [5:0] HDR_CONTEXT_PFX = 6'b011001;
    localparam logic [5:0] HDR_OPTYPE_PFX  = 6'b010010;
    localparam logic [5:0] HDR_EXT_PFX     = 6'b001000;
    localparam logic [1:0] HDR_CLASS_PFX   = 2'b01;
    localparam logic [3:0] HDR_EVENTS_SFX  = 4'b0010;
    localparam logic [3:0] HDR_SOURCE_SFX  = 4'b0011;

    localparam logic [4:0] ADDR_IDX_PC = 5'd0;
    localparam logic [4:0] ADDR_IDX_VA = 5'd2;
    localparam logic [4:0] ADDR_IDX_PA = 5'd3;

    localparam logic [63:0] MASK56   = 64'h00ff_ffff_ffff_ffff;
    localparam logic [63:0] TOP_BYTE = 64'hff00_0000_0000_0000;
    localparam logic [31:0] CONTEXT_NONE = 32'hffff_ffff;
    localparam logic [15:0] LIMIT_RESET  = 16'hffff;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_EXT,
        PH_CAPTURE,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        TGT_NONE,
        TGT_PC,
        TGT_VA,
        TGT_PA,
        TGT_EVENTS,
        TGT_CONTEXT,
        TGT_TIME
    } target_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [63:0] program_counter;
        logic [63:0] data_virtual_address;
        logic [55:0] data_physical_address;
        logic [63:0] event_bits;
        logic [31:0] context_id;
        logic [63:0] timestamp;
    } rec_t;

    typedef struct packed {
        logic       byte_en;
        logic [7:0] data;
        logic [2:0] pos;
        logic       finish;
        target_t    target;
        logic       emit;
        logic       clear;
    } op_t;

endpackage

>>> design/ptpd_stream_if.sv
interface ptpd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/ptpd_front.sv
module ptpd_front (
    input  logic              clk,
    input  logic              rst_n,
    ptpd_stream_if.sink       in_ch,
    ptpd_stream_if.sink       cfg_ch,
    input  logic              q_full,
    output logic              q_push,
    output ptpd_pkg::op_t     q_op
);

    ptpd_pkg::phase_t  phase_reg, phase_next;
    ptpd_pkg::target_t target_reg, target_next;
    logic [1:0]        ext_reg, ext_next;
    logic [3:0]        left_reg, left_next;
    logic [2:0]        pos_reg, pos_next;
    logic [15:0]       count_reg, count_next;
    logic [15:0]       limit_reg;
    logic              in_fire;
    logic              active;
    logic [7:0]        b;

    function automatic ptpd_pkg::target_t addr_target(input logic [4:0] idx);
        ptpd_pkg::target_t t;
        t = ptpd_pkg::TGT_NONE;
        if (idx == ptpd_pkg::ADDR_IDX_PC)
            t = ptpd_pkg::TGT_PC;
        else if (idx == ptpd_pkg::ADDR_IDX_VA)
            t = ptpd_pkg::TGT_VA;
        else if (idx == ptpd_pkg::ADDR_IDX_PA)
            t = ptpd_pkg::TGT_PA;
        return t;
    endfunction

    function automatic logic [3:0] size_of(input logic [7:0] h);
        return 4'd1 << h[5:4];
    endfunction

    assign in_ch.ready  = !q_full;
    assign cfg_ch.ready = 1'b1;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign active       = count_reg < limit_reg;
    assign b            = in_ch.payload.data_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        target_next = target_reg;
        ext_next    = ext_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        q_op        = '0;
        q_op.data   = b;
        q_op.target = target_reg;
        if (in_fire)
        begin
            if (active)
            begin
                case (phase_reg)
                    ptpd_pkg::PH_HEADER:
                    begin
                        ext_next = 2'd0;
                        if (b == ptpd_pkg::HDR_PAD)
                        begin
                            phase_next = ptpd_pkg::PH_HEADER;
                        end
                        else if (b == ptpd_pkg::HDR_END)
                        begin
                            q_op.emit  = 1'b1;
                            count_next = count_reg + 16'd1;
                        end
                        else if (b == ptpd_pkg::HDR_TIME)
                        begin
                            phase_next  = ptpd_pkg::PH_CAPTURE;
                            left_next   = size_of(b);
                            pos_next    = 3'd0;
                            target_next = ptpd_pkg::TGT_TIME;
                        end
                        else if (b[7:6] == ptpd_pkg::HDR_CLASS_PFX)
                        begin
                            if (b[3:0] == ptpd_pkg::HDR_EVENTS_SFX)
                            begin
                                phase_next  = ptpd_pkg::PH_CAPTURE;
                                left_next   = size_of(b);
                                pos_next    = 3'd0;
                                target_next = ptpd_pkg::TGT_EVENTS;
                            end
                            else if (b[7:2] == ptpd_pkg::HDR_CONTEXT_PFX)
                            begin
                                phase_next  = ptpd_pkg::PH_CAPTURE;
                                left_next   = size_of(b);
                                pos_next    = 3'd0;
                                target_next = ptpd_pkg::TGT_CONTEXT;
                            end
                            else if (b[3:0] == ptpd_pkg::HDR_SOURCE_SFX)
                            begin
                                phase_next = ptpd_pkg::PH_SKIP;
                                left_next  = size_of(b);
                            end
                            else if (b[7:2] == ptpd_pkg::HDR_OPTYPE_PFX)
                            begin
                                phase_next = ptpd_pkg::PH_SKIP;
                                left_next  = 4'd1;
                            end
                        end
                        else if (b[7:3] == ptpd_pkg::HDR_ADDR_PFX)
                        begin
                            phase_next  = ptpd_pkg::PH_CAPTURE;
                            left_next   = size_of(b);
                            pos_next    = 3'd0;
                            target_next = addr_target({2'b00, b[2:0]});
                        end
                        else if (b[7:3] == ptpd_pkg::HDR_COUNTER_PFX)
                        begin
                            phase_next = ptpd_pkg::PH_SKIP;
                            left_next  = 4'd2;
                        end
                        else if (b[7:2] == ptpd_pkg::HDR_EXT_PFX)
                        begin
                            phase_next = ptpd_pkg::PH_EXT;
                            ext_next   = b[1:0];
                        end
                    end
                    ptpd_pkg::PH_EXT:
                    begin
                        left_next = size_of(b);
                        if (b[7:3] == ptpd_pkg::HDR_ADDR_PFX)
                        begin
                            phase_next  = ptpd_pkg::PH_CAPTURE;
                            pos_next    = 3'd0;
                            target_next = addr_target({ext_reg, b[2:0]});
                        end
                        else
                        begin
                            phase_next = ptpd_pkg::PH_SKIP;
                        end
                    end
                    ptpd_pkg::PH_CAPTURE:
                    begin
                        q_op.byte_en = 1'b1;
                        q_op.pos     = pos_reg;
                        pos_next     = pos_reg + 3'd1;
                        left_next    = left_reg - 4'd1;
                        if (left_reg == 4'd1)
                        begin
                            q_op.finish = 1'b1;
                            phase_next  = ptpd_pkg::PH_HEADER;
                            if (target_reg == ptpd_pkg::TGT_TIME)
                            begin
                                q_op.emit  = 1'b1;
                                count_next = count_reg + 16'd1;
                            end
                        end
                    end
                    default:
                    begin
                        left_next = left_reg - 4'd1;
                        if (left_reg == 4'd1)
                            phase_next = ptpd_pkg::PH_HEADER;
                    end
                endcase
            end
            if (in_ch.payload.last_of_buffer)
            begin
                phase_next  = ptpd_pkg::PH_HEADER;
                target_next = ptpd_pkg::TGT_NONE;
                ext_next    = 2'd0;
                left_next   = 4'd0;
                pos_next    = 3'd0;
                count_next  = 16'd0;
                q_op.clear  = 1'b1;
            end
        end
        q_push = in_fire && (q_op.byte_en || q_op.emit || q_op.clear);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ptpd_pkg::PH_HEADER;
            target_reg <= ptpd_pkg::TGT_NONE;
            ext_reg    <= 2'd0;
            left_reg   <= 4'd0;
            pos_reg    <= 3'd0;
            count_reg  <= 16'd0;
            limit_reg  <= ptpd_pkg::LIMIT_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            ext_reg    <= ext_next;
            left_reg   <= left_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            if (cfg_ch.valid)
                limit_reg <= cfg_ch.payload;
        end
    end

endmodule

>>> design/ptpd_queue.sv
module ptpd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ptpd_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output ptpd_pkg::op_t head_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ptpd_pkg::op_t   mem [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> design/ptpd_back.sv
module ptpd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ptpd_pkg::op_t q_op,
    output logic          q_pop,
    ptpd_stream_if.source out_ch
);

    logic [63:0]    acc_reg, acc_next, acc_new;
    logic [63:0]    pc_reg, pc_next;
    logic [63:0]    va_reg, va_next;
    logic [55:0]    pa_reg, pa_next;
    logic [63:0]    ev_reg, ev_next;
    logic [31:0]    ctx_reg, ctx_next;
    logic [63:0]    time_reg, time_next;
    logic           out_valid_reg, out_valid_next;
    ptpd_pkg::rec_t out_reg, out_next;
    logic           out_free;

    function automatic logic [63:0] top_fix(input logic [63:0] v);
        logic [63:0] m;
        m = v & ptpd_pkg::MASK56;
        if (m[55:52] == 4'hf)
            m = m | ptpd_pkg::TOP_BYTE;
        return m;
    endfunction

    assign out_free       = !out_valid_reg || out_ch.ready;
    assign q_pop          = q_valid && (!q_op.emit || out_free);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;
    assign acc_new = ((q_op.pos == 3'd0) ? 64'd0 : acc_reg)
                   | ({56'd0, q_op.data} << {q_op.pos, 3'b000});

    always_comb
    begin
        acc_next       = acc_reg;
        pc_next        = pc_reg;
        va_next        = va_reg;
        pa_next        = pa_reg;
        ev_next        = ev_reg;
        ctx_next       = ctx_reg;
        time_next      = time_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (q_pop)
        begin
            if (q_op.byte_en)
                acc_next = acc_new;
            if (q_op.finish)
            begin
                case (q_op.target)
                    ptpd_pkg::TGT_PC:      pc_next   = top_fix(acc_new);
                    ptpd_pkg::TGT_VA:      va_next   = top_fix(acc_new);
                    ptpd_pkg::TGT_PA:      pa_next   = acc_new[55:0];
                    ptpd_pkg::TGT_EVENTS:  ev_next   = acc_new;
                    ptpd_pkg::TGT_CONTEXT: ctx_next  = acc_new[31:0];
                    ptpd_pkg::TGT_TIME:    time_next = acc_new;
                    default:               acc_next  = acc_new;
                endcase
            end
            if (q_op.emit)
            begin
                out_valid_next                 = 1'b1;
                out_next.program_counter       = pc_reg;
                out_next.data_virtual_address  = va_reg;
                out_next.data_physical_address = pa_reg;
                out_next.event_bits            = ev_reg;
                out_next.context_id            = ctx_reg;
                out_next.timestamp             = time_next;
            end
            if (q_op.emit || q_op.clear)
            begin
                pc_next   = 64'd0;
                va_next   = 64'd0;
                pa_next   = 56'd0;
                ev_next   = 64'd0;
                ctx_next  = ptpd_pkg::CONTEXT_NONE;
                time_next = 64'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 64'd0;
            va_reg        <= 64'd0;
            pa_reg        <= 56'd0;
            ev_reg        <= 64'd0;
            ctx_reg       <= ptpd_pkg::CONTEXT_NONE;
            time_reg      <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            va_reg        <= va_next;
            pa_reg        <= pa_next;
            ev_reg        <= ev_next;
            ctx_reg       <= ctx_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/profiling_trace_packet_decoder_top.sv
// Decoder for sampling-profiler trace packets, fed one trace-buffer byte per request.
// The in_ch channel carries data_byte and last_of_buffer; the out_ch channel carries
// one finished record, produced by an end packet or a completed timestamp packet.
// The cfg_ch channel writes record_limit, and it should be written only while idle.
// A byte is taken in every cycle while the command queue has room, so the sustained
// rate is one byte per cycle.
// The front end classifies each byte against the parser state and queues a command
// for payload bytes, record ends and buffer ends. The back end assembles payloads
// into the record and loads the output register. A finished record passes through
// the command queue and then the output register before it is shown on out_ch.
// When the receiver stalls, the output register holds its record, and the back end
// keeps taking commands until one needs to emit.
// Only then does the queue fill, and in_ch.ready drops while it is full.
// Reset clears the parser, the record (context id all ones), the emitted count,
// the queue and the output valid, and it sets record_limit to 65535.
// The last byte of a buffer is processed normally, and then the parser,
// the record and the count return to their reset values.
module profiling_trace_packet_decoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input logic         clk,
    input logic         rst_n,
    ptpd_stream_if.sink   in_ch,
    ptpd_stream_if.sink   cfg_ch,
    ptpd_stream_if.source out_ch
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    ptpd_pkg::op_t q_in_op;
    ptpd_pkg::op_t q_head_op;

    ptpd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (q_in_op)
    );

    ptpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_in_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head_op)
    );

    ptpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_head_op),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

>>> dv/profiling_trace_packet_decoder_checker.sv
module profiling_trace_packet_decoder_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  ptpd_pkg::in_item_t in_payload,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [15:0]       cfg_payload,
    input  logic              out_valid,
    input  logic              out_ready,
    input  ptpd_pkg::rec_t    out_payload,
    output int                fail_count,
    output int                pending_records
);
    timeunit 1ns;
    timeprecision 1ps;
    import ptpd_pkg::*;

    logic [15:0] limit_value;
    logic [15:0] emitted_count;
    phase_t      phase;
    logic [7:0]  hdr;
    logic [1:0]  ext_bits;
    logic [3:0]  bytes_left;
    logic [63:0] payload_acc;
    rec_t        assembling;
    rec_t        expected_records[$];
    int          errors = 0;

    function automatic logic [3:0] payload_size(logic [7:0] h);
        return 4'd1 << h[5:4];
    endfunction

    function automatic logic [63:0] fix_top_byte(logic [63:0] v);
        logic [63:0] r;
        r = v & MASK56;
        if (r[55:52] == 4'hf)
        begin
            r = r | TOP_BYTE;
        end
        return r;
    endfunction

    task clear_record();
        assembling = '0;
        assembling.context_id = CONTEXT_NONE;
    endtask

    task restart_parser();
        phase = PH_HEADER;
        hdr = '0;
        ext_bits = '0;
        bytes_left = '0;
        payload_acc = '0;
    endtask

    task reset_model();
        limit_value = LIMIT_RESET;
        emitted_count = '0;
        restart_parser();
        clear_record();
        expected_records.delete();
    endtask

    task push_record();
        expected_records.push_back(assembling);
        clear_record();
        emitted_count = emitted_count + 16'd1;
    endtask

    task begin_capture(input logic [7:0] h);
        hdr = h;
        bytes_left = payload_size(h);
        payload_acc = '0;
        phase = PH_CAPTURE;
    endtask

    task begin_skip(input logic [3:0] n);
        bytes_left = n;
        phase = PH_SKIP;
    endtask

    task finish_payload();
        logic [4:0] idx;
        phase = PH_HEADER;
        idx = {ext_bits, hdr[2:0]};
        if (hdr == HDR_TIME)
        begin
            assembling.timestamp = payload_acc;
            push_record();
        end
        else if (hdr[7:3] == HDR_ADDR_PFX)
        begin
            if (idx == ADDR_IDX_PC)
            begin
                assembling.program_counter = fix_top_byte(payload_acc);
            end
            else if (idx == ADDR_IDX_VA)
            begin
                assembling.data_virtual_address = fix_top_byte(payload_acc);
            end
            else if (idx == ADDR_IDX_PA)
            begin
                assembling.data_physical_address = payload_acc[55:0];
            end
        end
        else if (hdr[7:6] == HDR_CLASS_PFX && hdr[3:0] == HDR_EVENTS_SFX)
        begin
            assembling.event_bits = payload_acc;
        end
        else if (hdr[7:2] == HDR_CONTEXT_PFX)
        begin
            assembling.context_id = payload_acc[31:0];
        end
    endtask

    task take_header(input logic [7:0] b);
        ext_bits = '0;
        if (b == HDR_PAD)
        begin
        end
        else if (b == HDR_END)
        begin
            push_record();
        end
        else if (b == HDR_TIME)
        begin
            begin_capture(b);
        end
        else if (b[7:6] == HDR_CLASS_PFX)
        begin
            if (b[3:0] == HDR_EVENTS_SFX || b[7:2] == HDR_CONTEXT_PFX)
            begin
                begin_capture(b);
            end
            else if (b[3:0] == HDR_SOURCE_SFX)
            begin
                begin_skip(payload_size(b));
            end
            else if (b[7:2] == HDR_OPTYPE_PFX)
            begin
                begin_skip(4'd1);
            end
        end
        else if (b[7:3] == HDR_ADDR_PFX)
        begin
            begin_capture(b);
        end
        else if (b[7:3] == HDR_COUNTER_PFX)
        begin
            begin_skip(4'd2);
        end
        else if (b[7:2] == HDR_EXT_PFX)
        begin
            ext_bits = b[1:0];
            phase = PH_EXT;
        end
    endtask

    task decode_trace_byte(input logic [7:0] b, input logic last);
        logic [3:0] consumed;
        if (emitted_count < limit_value)
        begin
            case (phase)
                PH_HEADER:
                begin
                    take_header(b);
                end
                PH_EXT:
                begin
                    if (b[7:3] == HDR_ADDR_PFX)
                    begin
                        begin_capture(b);
                    end
                    else
                    begin
                        hdr = b;
                        begin_skip(payload_size(b));
                    end
                end
                PH_CAPTURE:
                begin
                    consumed = payload_size(hdr) - bytes_left;
                    payload_acc = payload_acc | (64'(b) << (8 * consumed[2:0]));
                    if (bytes_left > 0)
                    begin
                        bytes_left = bytes_left - 4'd1;
                    end
                    if (bytes_left == 0)
                    begin
                        finish_payload();
                    end
                end
                default:
                begin
                    if (bytes_left > 0)
                    begin
                        bytes_left = bytes_left - 4'd1;
                    end
                    if (bytes_left == 0)
                    begin
                        phase = PH_HEADER;
                    end
                end
            endcase
        end
        if (last)
        begin
            restart_parser();
            clear_record();
            emitted_count = '0;
        end
    endtask

    task compare_record(input rec_t want, input rec_t seen);
        logic [63:0] want_f [6];
        logic [63:0] seen_f [6];
        string       names [6];
        names = '{"program_counter", "data_virtual_address", "data_physical_address",
                  "event_bits", "context_id", "timestamp"};
        want_f = '{want.program_counter, want.data_virtual_address,
                   64'(want.data_physical_address), want.event_bits,
                   64'(want.context_id), want.timestamp};
        seen_f = '{seen.program_counter, seen.data_virtual_address,
                   64'(seen.data_physical_address), seen.event_bits,
                   64'(seen.context_id), seen.timestamp};
        for (int i = 0; i < 6; i++)
        begin
            if (seen_f[i] !== want_f[i])
            begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, names[i], want_f[i], seen_f[i]);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_value = cfg_payload;
            end
            if (in_valid && in_ready)
            begin
                decode_trace_byte(in_payload.data_byte, in_payload.last_of_buffer);
            end
            if (out_valid && out_ready)
            begin
                if (expected_records.size() == 0)
                begin
                    $display("%0t: record with none expected, expected nothing, actual %h",
                             $time, out_payload);
                    errors++;
                end
                else
                begin
                    compare_record(expected_records.pop_front(), out_payload);
                end
            end
        end
        fail_count <= errors;
        pending_records <= expected_records.size();
    end

endmodule

>>> dv/profiling_trace_packet_decoder_top_tb.sv
module profiling_trace_packet_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptpd_pkg::*;

    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [7:0] BAD_HDR     = 8'hff;
    localparam logic [7:0] BAD_EXT_HDR = 8'h0c;

    logic clk = 1'b0;
    logic rst_n;

    ptpd_stream_if #(.payload_t(in_item_t))    in_ch ();
    ptpd_stream_if #(.payload_t(logic [15:0])) cfg_ch ();
    ptpd_stream_if #(.payload_t(rec_t))        out_ch ();

    int fail_count;
    int pending_records;
    int sent_bytes = 0;
    int last_rate = 50;
    int idle_cycles = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_active = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    profiling_trace_packet_decoder_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    profiling_trace_packet_decoder_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .in_payload      (in_ch.payload),
        .cfg_valid       (cfg_ch.valid),
        .cfg_ready       (cfg_ch.ready),
        .cfg_payload     (cfg_ch.payload),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_payload     (out_ch.payload),
        .fail_count      (fail_count),
        .pending_records (pending_records)
    );

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
            || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver stalls in random bursts, and once for a long stretch on request.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_active)
            begin
                hold_active = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= in_item_t'{data_byte: b, last_of_buffer: last};
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sent_bytes++;
    endtask

    task send_trace_byte(input logic [7:0] b);
        send_byte(b, $urandom_range(1, last_rate) == 1);
    endtask

    task send_payload(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            if (i == 6 && $urandom_range(0, 1) == 1)
            begin
                b[7:4] = 4'hf;
            end
            send_trace_byte(b);
        end
    endtask

    task send_packet();
        int         kind;
        logic [1:0] s;
        logic [4:0] aidx;
        logic [7:0] b;
        kind = $urandom_range(0, 15);
        s = 2'($urandom);
        case (kind)
            0, 1:
            begin
                case ($urandom_range(0, 3))
                    0: aidx = ADDR_IDX_PC;
                    1: aidx = ADDR_IDX_VA;
                    2: aidx = ADDR_IDX_PA;
                    default: aidx = 5'($urandom);
                endcase
                if (aidx[4:3] != 2'b00 || $urandom_range(0, 3) == 0)
                begin
                    send_trace_byte({HDR_EXT_PFX, aidx[4:3]});
                end
                send_trace_byte({HDR_ADDR_PFX, aidx[2:0]});
                send_payload(8);
            end
            2, 3:
            begin
                send_trace_byte(HDR_TIME);
                send_payload(8);
            end
            4, 5:
            begin
                send_trace_byte(HDR_END);
            end
            6:
            begin
                send_trace_byte({HDR_CLASS_PFX, s, HDR_EVENTS_SFX});
                send_payload(1 << s);
            end
            7:
            begin
                send_trace_byte({HDR_CONTEXT_PFX, 2'($urandom)});
                send_payload(4);
            end
            8:
            begin
                send_trace_byte({HDR_OPTYPE_PFX, 2'($urandom)});
                send_payload(1);
            end
            9:
            begin
                send_trace_byte({HDR_CLASS_PFX, s, HDR_SOURCE_SFX});
                send_payload(1 << s);
            end
            10:
            begin
                send_trace_byte({HDR_COUNTER_PFX, 3'($urandom)});
                send_payload(2);
            end
            11:
            begin
                send_trace_byte({HDR_EXT_PFX, 2'($urandom)});
                send_trace_byte({HDR_COUNTER_PFX, 3'($urandom)});
                send_payload(2);
            end
            12:
            begin
                b = 8'($urandom);
                send_trace_byte({HDR_EXT_PFX, 2'($urandom)});
                send_trace_byte(b);
                send_payload(1 << b[5:4]);
            end
            13:
            begin
                send_trace_byte(HDR_PAD);
            end
            default:
            begin
                send_trace_byte(8'($urandom));
            end
        endcase
    endtask

    task run_random(input int n_bytes);
        int start;
        start = sent_bytes;
        while (sent_bytes - start < n_bytes)
        begin
            send_packet();
        end
    endtask

    task settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_records != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_limit(input logic [15:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task run_directed();
        logic [7:0] seq[$];
        seq = '{HDR_PAD,
                {HDR_OPTYPE_PFX, 2'b01}, 8'ha5,
                {HDR_CLASS_PFX, 2'b00, HDR_SOURCE_SFX}, 8'h5a,
                {HDR_COUNTER_PFX, 3'b111}, 8'hff, 8'h00,
                BAD_HDR,
                {HDR_CLASS_PFX, 2'b00, HDR_EVENTS_SFX}, 8'h81,
                {HDR_EXT_PFX, 2'b11}, BAD_EXT_HDR, 8'h7e,
                {HDR_ADDR_PFX, ADDR_IDX_PC[2:0]},
                8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'hf7, 8'h80,
                HDR_END};
        foreach (seq[i])
        begin
            send_byte(seq[i], i == seq.size() - 1);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        write_limit(LIMIT_RESET);
        run_directed();
        run_random(120);

        write_limit(16'd0);
        run_random(25);

        last_rate = 8;
        write_limit(16'd1);
        run_random(60);

        last_rate = 15;
        write_limit(16'd3);
        run_random(60);

        // Consecutive end packets while the receiver is held off fill the block.
        last_rate = 60;
        write_limit(LIMIT_RESET);
        hold_req = 1'b1;
        wait (hold_active);
        hold_req = 1'b0;
        repeat (12) send_byte(HDR_END, 1'b0);
        run_random(40);

        idle_on = 1'b0;
        run_random(100);

        settle();
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
